// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every rising clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dhoat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_pkg
// shared types and constants of the double hashed open address table
// ----------------------------------------------------------------------------
package dhoat_pkg;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int HASH_W   = 8;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 9;
	localparam int TAG_W    = 2;
	localparam int HASH_RANGE = 1 << HASH_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	// slot tag, code 3 never written and behaves as vacated
	typedef enum logic [TAG_W-1:0] {
		TAG_EMPTY = 2'd0,
		TAG_FULL  = 2'd1,
		TAG_GONE  = 2'd2
	} tag_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// port strobes of the slot memory
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctl_t;

endpackage

// ===== rtl/double_hash_open_address_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_address_table_top
// open addressed hash table with double hashing and vacated markers
// ----------------------------------------------------------------------------
//
// channel   handshake          payload
// -------   ----------------   ------------------------------------------
// command   start & !busy      op, key, value, first_hash, step_hash
// result    done (one cycle)   status, found_value, occupancy
//
// after reset the block sweeps the slot memory, one slot a cycle, marking
// every slot empty; busy stays high until the sweep is done
// an item reads its first slot in S_READ, then evaluates one probe a cycle
// in S_EVAL through the single memory read port, with 1 to NUM_SLOTS
// probes in all before its done strobe
// an unused op or an insert into a full table answers from idle, without probing
// busy is high while an item probes; the result cannot be stalled
//
`include "assert_macros.svh"

module double_hash_open_address_table_top #(
	parameter int NUM_SLOTS  = 256,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic [dhoat_pkg::OP_W-1:0]         op,
	input  logic [dhoat_pkg::KEY_W-1:0]        key,
	input  logic [dhoat_pkg::VALUE_W-1:0]      value,
	input  logic [dhoat_pkg::HASH_W-1:0]       first_hash,
	input  logic [dhoat_pkg::HASH_W-1:0]       step_hash,
	// result side
	output logic                               done,
	output logic [dhoat_pkg::STATUS_W-1:0]     status,
	output logic [dhoat_pkg::VALUE_W-1:0]      found_value,
	output logic [dhoat_pkg::OCC_W-1:0]        occupancy
);

	// slot index, entry count and stored field widths
	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int KW = (KEY_BITS < dhoat_pkg::KEY_W) ? KEY_BITS : dhoat_pkg::KEY_W;
	localparam int VW = (VALUE_BITS < dhoat_pkg::VALUE_W) ? VALUE_BITS : dhoat_pkg::VALUE_W;
	// memory word: tag, key, value
	localparam int WW = dhoat_pkg::TAG_W + KW + VW;

	// hash value reduced to a slot index, a constant table
	logic [IW-1:0] mod_tbl [dhoat_pkg::HASH_RANGE];

	for (genvar g = 0; g < dhoat_pkg::HASH_RANGE; g++) begin : g_mod_tbl
		assign mod_tbl[g] = IW'(g % NUM_SLOTS);
	end

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL
	} state_t;

	state_t                      state_q;
	logic [IW-1:0]               clr_q;
	dhoat_pkg::op_t              op_q;
	logic [KW-1:0]               key_q;
	logic [VW-1:0]               val_q;
	logic [IW-1:0]               step_q;
	logic [IW-1:0]               slot_q;     // next slot to read
	logic [IW-1:0]               addr_s1;    // slot whose word is on rd_word
	logic [IW-1:0]               probe_q;    // probe number under evaluation
	logic [IW-1:0]               free_q;     // first non-occupied slot seen
	logic                        free_v_q;
	logic [CW-1:0]               count_q;
	logic                        done_q;
	dhoat_pkg::status_t          status_q;
	logic [VW-1:0]               found_q;

	dhoat_pkg::ram_ctl_t         ram_ctl;
	logic [WW-1:0]               rd_word;
	logic [IW-1:0]               wr_addr;
	logic [WW-1:0]               wr_word;

	dhoat_pkg::tag_t             rd_tag;
	logic [KW-1:0]               rd_key;
	logic [VW-1:0]               rd_val;
	logic                        is_hit;
	logic                        is_empty;
	logic                        is_free;
	logic                        is_last;
	logic                        probe_end;
	logic                        have_free;
	logic [IW:0]                 slot_sum;
	logic [IW-1:0]               next_slot;
	logic                        accept;

	assign accept = start && !busy;

	// next probe: (slot + step) mod NUM_SLOTS, both operands already reduced
	always_comb begin
		slot_sum  = {1'b0, slot_q} + {1'b0, step_q};
		next_slot = (slot_sum >= (IW+1)'(NUM_SLOTS))
			? IW'(slot_sum - (IW+1)'(NUM_SLOTS)) : IW'(slot_sum);
	end

	// decode of the word read for the current probe
	always_comb begin
		rd_tag    = dhoat_pkg::tag_t'(rd_word[WW-1 -: dhoat_pkg::TAG_W]);
		rd_key    = rd_word[VW +: KW];
		rd_val    = rd_word[VW-1:0];
		is_hit    = (rd_tag == dhoat_pkg::TAG_FULL) && (rd_key == key_q);
		is_empty  = (rd_tag == dhoat_pkg::TAG_EMPTY);
		// vacated and the unused tag code both count as free
		is_free   = (rd_tag != dhoat_pkg::TAG_FULL);
		is_last   = (probe_q == IW'(NUM_SLOTS - 1));
		probe_end = is_hit || is_empty || is_last;
		have_free = free_v_q || is_free;
	end

	// memory port control
	always_comb begin
		ram_ctl = '0;
		wr_addr = addr_s1;
		wr_word = {dhoat_pkg::TAG_FULL, key_q, val_q};
		case (state_q)
			S_CLEAR: begin
				ram_ctl.wr_en = 1'b1;
				wr_addr       = clr_q;
				wr_word       = {dhoat_pkg::TAG_EMPTY, {(KW + VW){1'b0}}};
			end
			S_READ: begin
				ram_ctl.rd_en = 1'b1;
			end
			S_EVAL: begin
				if (!probe_end) begin
					ram_ctl.rd_en = 1'b1;
				end else if (is_hit && op_q == dhoat_pkg::OP_REMOVE) begin
					// mark the hit slot vacated, keep its contents
					ram_ctl.wr_en = 1'b1;
					wr_word       = {dhoat_pkg::TAG_GONE, rd_key, rd_val};
				end else if (!is_hit && op_q == dhoat_pkg::OP_INSERT && have_free) begin
					ram_ctl.wr_en = 1'b1;
					wr_addr       = free_v_q ? free_q : addr_s1;
				end
			end
			default: begin
				ram_ctl = '0;
			end
		endcase
	end

	dhoat_ram #(
		.DEPTH (NUM_SLOTS),
		.WIDTH (WW)
	) u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.rd_addr (slot_q),
		.rd_data (rd_word),
		.wr_addr (wr_addr),
		.wr_data (wr_word)
	);

	// sequencer, probe registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			op_q     <= dhoat_pkg::OP_INSERT;
			key_q    <= '0;
			val_q    <= '0;
			step_q   <= '0;
			slot_q   <= '0;
			addr_s1  <= '0;
			probe_q  <= '0;
			free_q   <= '0;
			free_v_q <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= dhoat_pkg::ST_OK;
			found_q  <= '0;
		end else begin
			done_q <= 1'b0;

			// read issue moves the probe address along
			if (ram_ctl.rd_en) begin
				slot_q  <= next_slot;
				addr_s1 <= slot_q;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(NUM_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q     <= dhoat_pkg::op_t'(op);
						key_q    <= key[KW-1:0];
						val_q    <= value[VW-1:0];
						slot_q   <= mod_tbl[first_hash];
						step_q   <= mod_tbl[step_hash];
						probe_q  <= '0;
						free_v_q <= 1'b0;
						case (dhoat_pkg::op_t'(op))
							dhoat_pkg::OP_INSERT: begin
								if (count_q >= CW'(NUM_SLOTS)) begin
									done_q   <= 1'b1;
									status_q <= dhoat_pkg::ST_FULL;
									found_q  <= '0;
								end else begin
									state_q <= S_READ;
								end
							end
							dhoat_pkg::OP_REMOVE: begin
								state_q <= S_READ;
							end
							dhoat_pkg::OP_LOOKUP: begin
								state_q <= S_READ;
							end
							default: begin
								// unused op: nothing changes
								done_q   <= 1'b1;
								status_q <= dhoat_pkg::ST_MISSING;
								found_q  <= '0;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!probe_end) begin
						probe_q <= probe_q + 1'b1;
						if (!free_v_q && is_free) begin
							free_q   <= addr_s1;
							free_v_q <= 1'b1;
						end
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						found_q <= '0;
						case (op_q)
							dhoat_pkg::OP_INSERT: begin
								if (is_hit) begin
									status_q <= dhoat_pkg::ST_PRESENT;
								end else if (have_free) begin
									status_q <= dhoat_pkg::ST_OK;
									count_q  <= count_q + 1'b1;
								end else begin
									status_q <= dhoat_pkg::ST_FULL;
								end
							end
							dhoat_pkg::OP_REMOVE: begin
								if (is_hit) begin
									status_q <= dhoat_pkg::ST_OK;
									found_q  <= rd_val;
									count_q  <= count_q - 1'b1;
								end else begin
									status_q <= dhoat_pkg::ST_MISSING;
								end
							end
							default: begin
								// lookup
								if (is_hit) begin
									status_q <= dhoat_pkg::ST_OK;
									found_q  <= rd_val;
								end else begin
									status_q <= dhoat_pkg::ST_MISSING;
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = dhoat_pkg::VALUE_W'(found_q);
	// occupancy wraps modulo 512 for tables larger than 511 slots
	assign occupancy   = dhoat_pkg::OCC_W'(count_q);

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------

	// a result is only reported once the probe sequencer has gone idle
	`ASSERT_IMPLIES(a_done_idle, done_q, state_q == S_IDLE, "result strobe while busy")

	// the entry count never exceeds the table size
	`ASSERT_ALWAYS(a_count_max, count_q <= CW'(NUM_SLOTS), "entry count above slot count")

	// the entry count moves only together with a result
	`ASSERT_IMPLIES(a_count_done, !$stable(count_q), done_q, "count changed without result")

	// a probe write comes only from insert or remove
	`ASSERT_IMPLIES(a_write_op, state_q == S_EVAL && ram_ctl.wr_en,
		op_q == dhoat_pkg::OP_INSERT || op_q == dhoat_pkg::OP_REMOVE,
		"slot write from lookup")

endmodule

// ===== rtl/dhoat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_ram
// slot memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module dhoat_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 66
) (
	input  logic                     clk,
	input  dhoat_pkg::ram_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
